// ----- hw/rtl/smi_pkg.sv -----
// Shared types, constants and saturating fixed-point helpers for the matrix inverse unit.
package smi_pkg;

    localparam int VBITS      = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PBITS      = 2 * VBITS;
    // quotient of 2^(2*FRAC_BITS) over a VBITS-bit magnitude needs VBITS+1 bits
    localparam int DIV_STAGES = VBITS + 1;

    localparam logic [2:0] SIZE_2X2 = 3'd2;
    localparam logic [2:0] SIZE_3X3 = 3'd3;

    typedef logic signed [VBITS-1:0] t_word;

    localparam t_word WORD_MAX = {1'b0, {(VBITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(VBITS-1){1'b0}}};

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_SQUARE = 2'd1,
        ST_BAD_SIZE   = 2'd2,
        ST_SINGULAR   = 2'd3
    } t_status;

    // payload that rides alongside the reciprocal pipeline
    typedef struct packed {
        t_status     status;
        t_word       det;
        t_word [8:0] adj;
    } t_side;

    // saturate a double-width value to one word
    function automatic t_word sat_wide(input logic signed [PBITS-1:0] v);
        if ((&v[PBITS-1:VBITS-1]) || !(|v[PBITS-1:VBITS-1])) begin
            return v[VBITS-1:0];
        end
        return v[PBITS-1] ? WORD_MIN : WORD_MAX;
    endfunction

    // product shifted right with floor rounding, then saturated
    function automatic t_word fx_mul(input t_word a, input t_word b);
        logic signed [PBITS-1:0] p;
        p = PBITS'(a) * PBITS'(b);
        return sat_wide(p >>> FRAC_BITS);
    endfunction

    function automatic t_word fx_add(input t_word a, input t_word b);
        logic signed [VBITS:0] s;
        s = {a[VBITS-1], a} + {b[VBITS-1], b};
        if (s[VBITS] != s[VBITS-1]) begin
            return s[VBITS] ? WORD_MIN : WORD_MAX;
        end
        return s[VBITS-1:0];
    endfunction

    function automatic t_word fx_sub(input t_word a, input t_word b);
        logic signed [VBITS:0] s;
        s = {a[VBITS-1], a} - {b[VBITS-1], b};
        if (s[VBITS] != s[VBITS-1]) begin
            return s[VBITS] ? WORD_MIN : WORD_MAX;
        end
        return s[VBITS-1:0];
    endfunction

    function automatic t_word fx_neg(input t_word a);
        return fx_sub('0, a);
    endfunction

endpackage

// ----- hw/rtl/smi_in_if.sv -----
// Input channel: one matrix with its row and column counts per beat.
interface smi_in_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  row_count;
    logic        [2:0]  col_count;
    logic signed [31:0] elem0;
    logic signed [31:0] elem1;
    logic signed [31:0] elem2;
    logic signed [31:0] elem3;
    logic signed [31:0] elem4;
    logic signed [31:0] elem5;
    logic signed [31:0] elem6;
    logic signed [31:0] elem7;
    logic signed [31:0] elem8;

    modport source (
        output valid, row_count, col_count,
        output elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7, elem8,
        input  ready
    );
    modport sink (
        input  valid, row_count, col_count,
        input  elem0, elem1, elem2, elem3, elem4, elem5, elem6, elem7, elem8,
        output ready
    );
endinterface

// ----- hw/rtl/smi_out_if.sv -----
// Output channel: status, determinant and inverse per beat.
interface smi_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  status;
    logic signed [31:0] determinant;
    logic signed [31:0] inv0;
    logic signed [31:0] inv1;
    logic signed [31:0] inv2;
    logic signed [31:0] inv3;
    logic signed [31:0] inv4;
    logic signed [31:0] inv5;
    logic signed [31:0] inv6;
    logic signed [31:0] inv7;
    logic signed [31:0] inv8;

    modport source (
        output valid, status, determinant,
        output inv0, inv1, inv2, inv3, inv4, inv5, inv6, inv7, inv8,
        input  ready
    );
    modport sink (
        input  valid, status, determinant,
        input  inv0, inv1, inv2, inv3, inv4, inv5, inv6, inv7, inv8,
        output ready
    );
endinterface

// ----- hw/rtl/smi_recip.sv -----
// Pipelined restoring divider: 2^(2*FRAC_BITS) / |det|, one quotient bit per stage.
module smi_recip (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  smi_pkg::t_side                      i_side,
    input  logic [smi_pkg::VBITS-1:0]           i_dvs,
    input  logic                                i_neg,
    output logic                                o_vld,
    output smi_pkg::t_side                      o_side,
    output logic [smi_pkg::DIV_STAGES-1:0]      o_quo,
    output logic                                o_neg
);
    import smi_pkg::*;

    logic                    r_vld  [DIV_STAGES];
    logic [VBITS-1:0]        r_rem  [DIV_STAGES];
    logic [DIV_STAGES-1:0]   r_quo  [DIV_STAGES];
    logic [VBITS-1:0]        r_dvs  [DIV_STAGES];
    logic                    r_neg  [DIV_STAGES];
    t_side                   r_side [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            // dividend is a single one in its top bit
            localparam logic NBIT = (k == 0);

            logic                  w_vld;
            logic [VBITS-1:0]      w_rem;
            logic [DIV_STAGES-1:0] w_quo;
            logic [VBITS-1:0]      w_dvs;
            logic                  w_neg;
            t_side                 w_side;
            logic [VBITS:0]        n_sh;
            logic [VBITS:0]        n_diff;
            logic                  n_ge;

            if (k == 0) begin : g_head
                assign w_vld  = i_vld;
                assign w_rem  = '0;
                assign w_quo  = '0;
                assign w_dvs  = i_dvs;
                assign w_neg  = i_neg;
                assign w_side = i_side;
            end else begin : g_body
                assign w_vld  = r_vld[k-1];
                assign w_rem  = r_rem[k-1];
                assign w_quo  = r_quo[k-1];
                assign w_dvs  = r_dvs[k-1];
                assign w_neg  = r_neg[k-1];
                assign w_side = r_side[k-1];
            end

            // shift in the next dividend bit, trial subtract
            assign n_sh   = {w_rem, NBIT};
            assign n_diff = n_sh - {1'b0, w_dvs};
            assign n_ge   = (n_sh >= {1'b0, w_dvs});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= w_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_ge ? n_diff[VBITS-1:0] : n_sh[VBITS-1:0];
                    r_quo[k]  <= {w_quo[DIV_STAGES-2:0], n_ge};
                    r_dvs[k]  <= w_dvs;
                    r_neg[k]  <= w_neg;
                    r_side[k] <= w_side;
                end
            end
        end
    endgenerate

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];
    assign o_quo  = r_quo[DIV_STAGES-1];
    assign o_neg  = r_neg[DIV_STAGES-1];

endmodule

// ----- hw/rtl/smi_front.sv -----
// Front end: pair products, Sarrus terms, adjugate and determinant over four stages.
module smi_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [2:0]                  i_rows,
    input  logic [2:0]                  i_cols,
    input  smi_pkg::t_word [8:0]        i_elem,
    output logic                        o_vld,
    output smi_pkg::t_side              o_side,
    output logic [smi_pkg::VBITS-1:0]   o_dvs,
    output logic                        o_neg
);
    import smi_pkg::*;

    typedef struct packed {
        t_status     status;
        logic        is3;
        t_word [8:0] e;
        t_word m48, m57, m18, m27, m15, m24, m38, m56, m08, m26;
        t_word m05, m23, m37, m46, m07, m16, m04, m13, m03, m12;
    } t_s1;

    typedef struct packed {
        t_status     status;
        logic        is3;
        t_word       det2;
        t_word       aei, bfg, cdh, ceg, bdi, afh;
        t_word [8:0] adj;
    } t_s2;

    typedef struct packed {
        t_status     status;
        logic        is3;
        t_word       det2;
        t_word       pos;
        t_word       neg;
        t_word [8:0] adj;
    } t_s3;

    logic       r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    t_s1        r_s1, n_s1;
    t_s2        r_s2, n_s2;
    t_s3        r_s3, n_s3;
    t_side      r_s4, n_s4;
    logic [VBITS-1:0] r_dvs, n_dvs;
    logic       r_neg, n_neg;

    // stage 1: size check and all pair products
    always_comb begin
        n_s1.e   = i_elem;
        n_s1.is3 = (i_rows == SIZE_3X3);
        if (i_rows != i_cols) begin
            n_s1.status = ST_NOT_SQUARE;
        end else if (i_rows != SIZE_2X2 && i_rows != SIZE_3X3) begin
            n_s1.status = ST_BAD_SIZE;
        end else begin
            n_s1.status = ST_OK;
        end
        n_s1.m48 = fx_mul(i_elem[4], i_elem[8]);
        n_s1.m57 = fx_mul(i_elem[5], i_elem[7]);
        n_s1.m18 = fx_mul(i_elem[1], i_elem[8]);
        n_s1.m27 = fx_mul(i_elem[2], i_elem[7]);
        n_s1.m15 = fx_mul(i_elem[1], i_elem[5]);
        n_s1.m24 = fx_mul(i_elem[2], i_elem[4]);
        n_s1.m38 = fx_mul(i_elem[3], i_elem[8]);
        n_s1.m56 = fx_mul(i_elem[5], i_elem[6]);
        n_s1.m08 = fx_mul(i_elem[0], i_elem[8]);
        n_s1.m26 = fx_mul(i_elem[2], i_elem[6]);
        n_s1.m05 = fx_mul(i_elem[0], i_elem[5]);
        n_s1.m23 = fx_mul(i_elem[2], i_elem[3]);
        n_s1.m37 = fx_mul(i_elem[3], i_elem[7]);
        n_s1.m46 = fx_mul(i_elem[4], i_elem[6]);
        n_s1.m07 = fx_mul(i_elem[0], i_elem[7]);
        n_s1.m16 = fx_mul(i_elem[1], i_elem[6]);
        n_s1.m04 = fx_mul(i_elem[0], i_elem[4]);
        n_s1.m13 = fx_mul(i_elem[1], i_elem[3]);
        n_s1.m03 = fx_mul(i_elem[0], i_elem[3]);
        n_s1.m12 = fx_mul(i_elem[1], i_elem[2]);
    end

    // stage 2: triple products, cofactors, 2x2 determinant
    always_comb begin
        n_s2.status = r_s1.status;
        n_s2.is3    = r_s1.is3;
        n_s2.det2   = fx_sub(r_s1.m03, r_s1.m12);
        n_s2.aei    = fx_mul(r_s1.m04, r_s1.e[8]);
        n_s2.bfg    = fx_mul(r_s1.m15, r_s1.e[6]);
        n_s2.cdh    = fx_mul(r_s1.m23, r_s1.e[7]);
        n_s2.ceg    = fx_mul(r_s1.m24, r_s1.e[6]);
        n_s2.bdi    = fx_mul(r_s1.m13, r_s1.e[8]);
        n_s2.afh    = fx_mul(r_s1.m05, r_s1.e[7]);
        if (r_s1.is3) begin
            n_s2.adj[0] = fx_sub(r_s1.m48, r_s1.m57);
            n_s2.adj[1] = fx_neg(fx_sub(r_s1.m18, r_s1.m27));
            n_s2.adj[2] = fx_sub(r_s1.m15, r_s1.m24);
            n_s2.adj[3] = fx_neg(fx_sub(r_s1.m38, r_s1.m56));
            n_s2.adj[4] = fx_sub(r_s1.m08, r_s1.m26);
            n_s2.adj[5] = fx_neg(fx_sub(r_s1.m05, r_s1.m23));
            n_s2.adj[6] = fx_sub(r_s1.m37, r_s1.m46);
            n_s2.adj[7] = fx_neg(fx_sub(r_s1.m07, r_s1.m16));
            n_s2.adj[8] = fx_sub(r_s1.m04, r_s1.m13);
        end else begin
            n_s2.adj    = '0;
            n_s2.adj[0] = r_s1.e[3];
            n_s2.adj[1] = fx_neg(r_s1.e[1]);
            n_s2.adj[2] = fx_neg(r_s1.e[2]);
            n_s2.adj[3] = r_s1.e[0];
        end
    end

    // stage 3: positive and negative Sarrus sums
    always_comb begin
        n_s3.status = r_s2.status;
        n_s3.is3    = r_s2.is3;
        n_s3.det2   = r_s2.det2;
        n_s3.adj    = r_s2.adj;
        n_s3.pos    = fx_add(fx_add(r_s2.aei, r_s2.bfg), r_s2.cdh);
        n_s3.neg    = fx_add(fx_add(r_s2.ceg, r_s2.bdi), r_s2.afh);
    end

    // stage 4: determinant, singular check, divisor magnitude
    always_comb begin
        n_s4.adj    = r_s3.adj;
        n_s4.det    = r_s3.is3 ? fx_sub(r_s3.pos, r_s3.neg) : r_s3.det2;
        n_s4.status = r_s3.status;
        if (r_s3.status == ST_OK && n_s4.det == '0) begin
            n_s4.status = ST_SINGULAR;
        end
        n_neg = n_s4.det[VBITS-1];
        n_dvs = n_neg ? (VBITS'(0) - n_s4.det) : n_s4.det;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_s3  <= n_s3;
            r_s4  <= n_s4;
            r_dvs <= n_dvs;
            r_neg <= n_neg;
        end
    end

    assign o_vld  = r_s4_vld;
    assign o_side = r_s4;
    assign o_dvs  = r_dvs;
    assign o_neg  = r_neg;

endmodule

// ----- hw/rtl/smi_scale.sv -----
// Back end: signed saturated reciprocal, then adjugate scaling into the output register.
module smi_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_vld,
    input  smi_pkg::t_side                      i_side,
    input  logic [smi_pkg::DIV_STAGES-1:0]      i_quo,
    input  logic                                i_neg,
    output logic                                o_vld,
    output smi_pkg::t_status                    o_status,
    output smi_pkg::t_word                      o_det,
    output smi_pkg::t_word [8:0]                o_inv
);
    import smi_pkg::*;

    logic                    r_r_vld, r_out_vld;
    t_side                   r_side;
    t_word                   r_recip, n_recip;
    t_status                 r_status;
    t_word                   r_det, n_det;
    t_word [8:0]             r_inv, n_inv;
    logic signed [VBITS+1:0] n_sq;

    // apply sign to the quotient and saturate
    always_comb begin
        n_sq = $signed({1'b0, i_quo});
        if (i_neg) begin
            n_sq = -n_sq;
        end
        if (n_sq > $signed({{2{WORD_MAX[VBITS-1]}}, WORD_MAX})) begin
            n_recip = WORD_MAX;
        end else if (n_sq < $signed({{2{WORD_MIN[VBITS-1]}}, WORD_MIN})) begin
            n_recip = WORD_MIN;
        end else begin
            n_recip = n_sq[VBITS-1:0];
        end
    end

    // scale adjugate; any error zeroes the determinant and the inverse, status passes through
    always_comb begin
        n_det = '0;
        n_inv = '0;
        if (r_side.status == ST_OK) begin
            n_det = r_side.det;
            for (int i = 0; i < 9; i++) begin
                n_inv[i] = fx_mul(r_side.adj[i], r_recip);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_r_vld   <= i_vld;
            r_out_vld <= r_r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side   <= i_side;
            r_recip  <= n_recip;
            r_status <= r_side.status;
            r_det    <= n_det;
            r_inv    <= n_inv;
        end
    end

    assign o_vld    = r_out_vld;
    assign o_status = r_status;
    assign o_det    = r_det;
    assign o_inv    = r_inv;

endmodule

// ----- hw/rtl/small_matrix_inverse_unit.sv -----
// Top level of the 2x2 / 3x3 fixed-point matrix inverse unit.
//
// Input channel i_in carries one matrix per beat: row and column counts and
// nine row-major Q16.16 elements (only the first four used for 2x2).
// Output channel o_out returns one beat per matrix: status (ok, not square,
// unsupported size, singular), the saturated determinant and the row-major
// inverse; every field but status is zero on an error.
// Each matrix passes through 39 register stages: four stages of products,
// cofactors and determinant, 33 stages of the restoring divider that forms
// the reciprocal one quotient bit per stage, one stage for the signed
// reciprocal and one for the adjugate scaling into the output register.
// Throughput is one matrix per cycle while o_out.ready is high.
// The whole pipeline shares one advance enable: when the output register holds
// a beat and o_out.ready is low, every stage holds and i_in.ready drops; no
// beat is lost or repeated. i_in.ready stays high while the output is free.
// Reset (i_rst_n low, synchronous) empties all stage valid bits; no payload
// register is cleared.
module small_matrix_inverse_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smi_in_if.sink    i_in,
    smi_out_if.source o_out
);
    import smi_pkg::*;

    logic                   w_en;
    t_word [8:0]            w_elem;
    logic                   w_f_vld, w_d_vld, w_s_vld;
    t_side                  w_f_side, w_d_side;
    logic [VBITS-1:0]       w_dvs;
    logic                   w_f_neg, w_d_neg;
    logic [DIV_STAGES-1:0]  w_quo;
    t_status                w_status;
    t_word                  w_det;
    t_word [8:0]            w_inv;

    // advance whenever the output register is empty or being drained
    assign w_en       = !w_s_vld || o_out.ready;
    assign i_in.ready = w_en;

    assign w_elem = {i_in.elem8, i_in.elem7, i_in.elem6, i_in.elem5, i_in.elem4,
                     i_in.elem3, i_in.elem2, i_in.elem1, i_in.elem0};

    smi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_rows  (i_in.row_count),
        .i_cols  (i_in.col_count),
        .i_elem  (w_elem),
        .o_vld   (w_f_vld),
        .o_side  (w_f_side),
        .o_dvs   (w_dvs),
        .o_neg   (w_f_neg)
    );

    smi_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_f_vld),
        .i_side  (w_f_side),
        .i_dvs   (w_dvs),
        .i_neg   (w_f_neg),
        .o_vld   (w_d_vld),
        .o_side  (w_d_side),
        .o_quo   (w_quo),
        .o_neg   (w_d_neg)
    );

    smi_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (w_d_vld),
        .i_side   (w_d_side),
        .i_quo    (w_quo),
        .i_neg    (w_d_neg),
        .o_vld    (w_s_vld),
        .o_status (w_status),
        .o_det    (w_det),
        .o_inv    (w_inv)
    );

    // output beat
    assign o_out.valid       = w_s_vld;
    assign o_out.status      = w_status;
    assign o_out.determinant = w_det;
    assign o_out.inv0        = w_inv[0];
    assign o_out.inv1        = w_inv[1];
    assign o_out.inv2        = w_inv[2];
    assign o_out.inv3        = w_inv[3];
    assign o_out.inv4        = w_inv[4];
    assign o_out.inv5        = w_inv[5];
    assign o_out.inv6        = w_inv[6];
    assign o_out.inv7        = w_inv[7];
    assign o_out.inv8        = w_inv[8];

endmodule

// ----- tb/small_matrix_inverse_unit_tb.sv -----
// Testbench for the matrix inverse unit: directed and random matrices checked against a predictor.
module small_matrix_inverse_unit_tb;
    import smi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] det;
        logic [31:0] inv [9];
    } t_inverse;

    logic i_clk;
    logic i_rst_n;
    int   n_errors;
    bit   no_idle;
    t_inverse inverse_q [$];

    smi_in_if  in_ch ();
    smi_out_if out_ch ();

    small_matrix_inverse_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run-time limit
    initial begin
        #2000000;
        $display("** small_matrix_inverse_unit: FAILED **");
        $finish;
    end

    // saturate to one 32-bit word
    function automatic longint clamp(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor-shifted product
    function automatic longint qmul(input longint a, input longint b);
        return clamp((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint qcross(input longint a, b, c, d);
        return clamp(qmul(a, b) - qmul(c, d));
    endfunction

    function automatic t_inverse predict_inverse(input logic [2:0] rc, input logic [2:0] cc,
                                                 input logic [31:0] el [9]);
        t_inverse res;
        longint e [9];
        longint adj [9];
        longint det, pos, ng, r;
        res.status = ST_OK;
        res.det = '0;
        for (int i = 0; i < 9; i++) begin
            res.inv[i] = '0;
            e[i] = longint'(signed'(el[i]));
        end
        det = 0;
        if (rc != cc) begin
            res.status = ST_NOT_SQUARE;
            return res;
        end
        if (rc != SIZE_2X2 && rc != SIZE_3X3) begin
            res.status = ST_BAD_SIZE;
            return res;
        end
        if (rc == SIZE_2X2) begin
            det = qcross(e[0], e[3], e[1], e[2]);
        end else begin
            pos = clamp(clamp(qmul(qmul(e[0], e[4]), e[8]) + qmul(qmul(e[1], e[5]), e[6]))
                        + qmul(qmul(e[2], e[3]), e[7]));
            ng  = clamp(clamp(qmul(qmul(e[2], e[4]), e[6]) + qmul(qmul(e[1], e[3]), e[8]))
                        + qmul(qmul(e[0], e[5]), e[7]));
            det = clamp(pos - ng);
        end
        if (det == 0) begin
            res.status = ST_SINGULAR;
            return res;
        end
        r = clamp((64'sd1 << (2 * FRAC_BITS)) / det);
        res.det = det[31:0];
        if (rc == SIZE_2X2) begin
            res.inv[0] = 32'(qmul(e[3], r));
            res.inv[1] = 32'(qmul(clamp(-e[1]), r));
            res.inv[2] = 32'(qmul(clamp(-e[2]), r));
            res.inv[3] = 32'(qmul(e[0], r));
        end else begin
            adj[0] = qcross(e[4], e[8], e[5], e[7]);
            adj[1] = clamp(-qcross(e[1], e[8], e[2], e[7]));
            adj[2] = qcross(e[1], e[5], e[2], e[4]);
            adj[3] = clamp(-qcross(e[3], e[8], e[5], e[6]));
            adj[4] = qcross(e[0], e[8], e[2], e[6]);
            adj[5] = clamp(-qcross(e[0], e[5], e[2], e[3]));
            adj[6] = qcross(e[3], e[7], e[4], e[6]);
            adj[7] = clamp(-qcross(e[0], e[7], e[1], e[6]));
            adj[8] = qcross(e[0], e[4], e[1], e[3]);
            for (int i = 0; i < 9; i++) res.inv[i] = 32'(qmul(adj[i], r));
        end
        return res;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 29);
    endfunction

    // send one matrix beat and record its expected result
    task automatic send_matrix(input logic [2:0] rc, input logic [2:0] cc,
                               input logic [31:0] el [9]);
        while (idle_now()) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.row_count <= rc;
        in_ch.col_count <= cc;
        in_ch.elem0 <= el[0]; in_ch.elem1 <= el[1]; in_ch.elem2 <= el[2];
        in_ch.elem3 <= el[3]; in_ch.elem4 <= el[4]; in_ch.elem5 <= el[5];
        in_ch.elem6 <= el[6]; in_ch.elem7 <= el[7]; in_ch.elem8 <= el[8];
        inverse_q.push_back(predict_inverse(rc, cc, el));
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // random element: mostly modest values within +/-3.0, some tiny, some extreme or full range
    function automatic logic [31:0] rand_elem();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2:       return 32'(signed'($urandom_range(64)) - 32);
            default: return 32'(signed'($urandom_range(32'h6_0000)) - 32'sh3_0000);
        endcase
    endfunction

    task automatic test_bad_shapes();
        logic [31:0] el [9];
        for (int i = 0; i < 9; i++) el[i] = 32'h0001_0000;
        send_matrix(3'd2, 3'd3, el);
        send_matrix(3'd7, 3'd0, el);
        send_matrix(3'd0, 3'd0, el);
        send_matrix(3'd1, 3'd1, el);
        send_matrix(3'd4, 3'd4, el);
        send_matrix(3'd7, 3'd7, el);
    endtask

    task automatic test_directed_values();
        logic [31:0] el [9];
        // identity, both sizes
        el = '{32'h1_0000, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000};
        send_matrix(3'd3, 3'd3, el);
        el = '{32'h1_0000, 0, 0, 32'h1_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        send_matrix(3'd2, 3'd2, el);
        // singular: all zero and equal rows
        for (int i = 0; i < 9; i++) el[i] = 0;
        send_matrix(3'd2, 3'd2, el);
        send_matrix(3'd3, 3'd3, el);
        for (int i = 0; i < 9; i++) el[i] = 32'h2_0000;
        send_matrix(3'd3, 3'd3, el);
        // extremes: saturating products and tiny determinants
        for (int i = 0; i < 9; i++) el[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        send_matrix(3'd2, 3'd2, el);
        send_matrix(3'd3, 3'd3, el);
        el = '{32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0};
        send_matrix(3'd2, 3'd2, el);
        el = '{32'h100, 0, 0, 32'h100, 0, 0, 0, 0, 0};
        send_matrix(3'd2, 3'd2, el);
        el = '{1, 0, 0, 0, 32'h1_0000, 0, 0, 0, 32'h1_0000};
        send_matrix(3'd3, 3'd3, el);
        el = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
               32'hFFFF_0000, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000};
        send_matrix(3'd3, 3'd3, el);
    endtask

    task automatic test_random_matrices(input int count);
        logic [31:0] el [9];
        logic [2:0] rc, cc;
        for (int n = 0; n < count; n++) begin
            no_idle = (n >= count / 2) && (n < count / 2 + 200);
            for (int i = 0; i < 9; i++) el[i] = rand_elem();
            if ($urandom_range(9) < 8) begin
                rc = $urandom_range(1) ? SIZE_3X3 : SIZE_2X2;
                cc = rc;
            end else begin
                rc = 3'($urandom);
                cc = $urandom_range(1) ? rc : 3'($urandom);
            end
            send_matrix(rc, cc, el);
        end
        no_idle = 1'b0;
    endtask

    // result sink: random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else          out_ch.ready <= !idle_now();
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_inverse exp_r;
        logic [31:0] got [9];
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.inv0, out_ch.inv1, out_ch.inv2, out_ch.inv3, out_ch.inv4,
                    out_ch.inv5, out_ch.inv6, out_ch.inv7, out_ch.inv8};
            if (inverse_q.size() == 0) begin
                $error("unexpected result beat");
                n_errors++;
            end else begin
                exp_r = inverse_q.pop_front();
                if (out_ch.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, out_ch.status);
                    n_errors++;
                end
                if (out_ch.determinant !== exp_r.det) begin
                    $error("determinant: expected %h, got %h", exp_r.det, out_ch.determinant);
                    n_errors++;
                end
                for (int i = 0; i < 9; i++) begin
                    if (got[i] !== exp_r.inv[i]) begin
                        $error("inv%0d: expected %h, got %h", i, exp_r.inv[i], got[i]);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin
        int guard;
        n_errors = 0;
        no_idle  = 1'b0;
        i_rst_n  = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.row_count = '0; in_ch.col_count = '0;
        in_ch.elem0 = '0; in_ch.elem1 = '0; in_ch.elem2 = '0;
        in_ch.elem3 = '0; in_ch.elem4 = '0; in_ch.elem5 = '0;
        in_ch.elem6 = '0; in_ch.elem7 = '0; in_ch.elem8 = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_bad_shapes();
        test_directed_values();
        test_random_matrices(2000);
        in_ch.valid <= 1'b0;
        // drain
        guard = 0;
        while (inverse_q.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        if (inverse_q.size() != 0) begin
            $error("%0d results never arrived", inverse_q.size());
            n_errors++;
        end
        repeat (50) @(posedge i_clk);
        if (n_errors == 0) $display("** small_matrix_inverse_unit: PASSED **");
        else               $display("** small_matrix_inverse_unit: FAILED **");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/smi_pkg.sv
hw/rtl/smi_in_if.sv
hw/rtl/smi_out_if.sv
hw/rtl/smi_recip.sv
hw/rtl/smi_front.sv
hw/rtl/smi_scale.sv
hw/rtl/small_matrix_inverse_unit.sv
tb/small_matrix_inverse_unit_tb.sv
